>>> sv/sme_pkg.sv
// Shared types, character codes and helper functions for the SIP message body extractor.
// Used by sme_core, sme_result_fifo and the top level; depends on nothing else.
package sme_pkg;

    localparam int SME_MAX_BODY_BYTES = 65535;

    localparam int SME_FIFO_DEPTH = 8;
    localparam int SME_PTR_W      = 3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ALT_L = 8'h6C;

    localparam logic [3:0] SME_KEY_LEN     = 4'd14;
    localparam logic [3:0] SME_KEY_ALT_LEN = 4'd1;
    localparam logic [3:0] SME_KEY_POS_MAX = 4'd15;

    localparam logic RK_BODY   = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    typedef enum logic [2:0] {
        SP_NONE,
        SP_CR,
        SP_CRLF,
        SP_CRLFCR,
        SP_LF
    } sep_state_t;

    typedef enum logic [2:0] {
        LP_LEAD,
        LP_KEY,
        LP_KEY_TRAIL,
        LP_VALUE,
        LP_SKIP
    } line_phase_t;

    typedef enum logic [2:0] {
        VS_EMPTY,
        VS_SIGN,
        VS_DIGITS,
        VS_TRAIL,
        VS_BAD
    } value_state_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  body_byte;
        logic        header_found;
        logic        length_used;
        logic [15:0] body_length;
        logic        is_last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } core_out_t;

    function automatic logic sme_is_ws(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic [7:0] sme_to_lower(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? b + 8'h20 : b;
    endfunction

    function automatic logic [7:0] sme_key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> sv/sme_core.sv
// Per-byte message state: separator search, header key match, length parse and body count.
// Produces up to two results per byte. Depends on sme_pkg.
module sme_core
    import sme_pkg::*;
#(
    parameter int MAX_BODY_BYTES = SME_MAX_BODY_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output core_out_t  results
);

    localparam int LEN_W = $clog2(MAX_BODY_BYTES + 2);
    localparam int CNT_W = $clog2(MAX_BODY_BYTES + 1);
    localparam logic [LEN_W-1:0] MAX_L    = LEN_W'(MAX_BODY_BYTES);
    localparam logic [LEN_W-1:0] MAX_P1   = LEN_W'(MAX_BODY_BYTES + 1);
    localparam logic [LEN_W+3:0] MAX_P1_W = (LEN_W + 4)'(MAX_BODY_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_BODY_BYTES);

    logic             section_reg, section_next;
    sep_state_t       sep_reg, sep_next;
    line_phase_t      phase_reg, phase_next;
    logic [3:0]       kpos_reg, kpos_next;
    logic             kmis_reg, kmis_next;
    logic             amis_reg, amis_next;
    logic             taken_reg, taken_next;
    value_state_t     vstate_reg, vstate_next;
    logic             neg_reg, neg_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             ws, dig, key_step, key_end, val_step, sep_done, emit;
    logic             key_hit, found, used;
    logic [7:0]       lc;
    logic [LEN_W+3:0] len_ext, len_x10;
    logic [31:0]      count_wide;
    result_t          body_res, status_res;

    function automatic logic length_ok(input logic tk, input value_state_t vs,
                                       input logic ng, input logic [LEN_W-1:0] lv);
        return tk && (vs == VS_DIGITS || vs == VS_TRAIL) && !(ng && lv != '0) &&
               lv <= MAX_L;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_reg <= 1'b0;
            sep_reg     <= SP_NONE;
            phase_reg   <= LP_LEAD;
            kpos_reg    <= '0;
            kmis_reg    <= 1'b0;
            amis_reg    <= 1'b0;
            taken_reg   <= 1'b0;
            vstate_reg  <= VS_EMPTY;
            neg_reg     <= 1'b0;
            len_reg     <= '0;
            count_reg   <= '0;
        end else begin
            section_reg <= section_next;
            sep_reg     <= sep_next;
            phase_reg   <= phase_next;
            kpos_reg    <= kpos_next;
            kmis_reg    <= kmis_next;
            amis_reg    <= amis_next;
            taken_reg   <= taken_next;
            vstate_reg  <= vstate_next;
            neg_reg     <= neg_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
        end
    end

    always_comb begin
        section_next = section_reg;
        sep_next     = sep_reg;
        phase_next   = phase_reg;
        kpos_next    = kpos_reg;
        kmis_next    = kmis_reg;
        amis_next    = amis_reg;
        taken_next   = taken_reg;
        vstate_next  = vstate_reg;
        neg_next     = neg_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        key_step     = 1'b0;
        key_end      = 1'b0;
        val_step     = 1'b0;
        sep_done     = 1'b0;
        emit         = 1'b0;
        ws           = sme_is_ws(in_byte);
        dig          = in_byte inside {[8'h30:8'h39]};
        lc           = sme_to_lower(in_byte);
        len_ext      = (LEN_W + 4)'(len_reg);
        len_x10      = (len_ext << 3) + (len_ext << 1) + (LEN_W + 4)'(in_byte[3:0]);
        key_hit      = (kpos_reg == SME_KEY_LEN && !kmis_reg) ||
                       (kpos_reg == SME_KEY_ALT_LEN && !amis_reg);

        if (step) begin
            if (!section_reg) begin
                if (in_byte == CH_LF) begin
                    phase_next = LP_LEAD;
                    kpos_next  = '0;
                    kmis_next  = 1'b0;
                    amis_next  = 1'b0;
                end else begin
                    case (phase_reg)
                        LP_LEAD: begin
                            if (!ws) begin
                                if (in_byte == CH_COLON) begin
                                    phase_next = LP_SKIP;
                                end else begin
                                    key_step   = 1'b1;
                                    phase_next = LP_KEY;
                                end
                            end
                        end
                        LP_KEY: begin
                            if (ws) begin
                                phase_next = LP_KEY_TRAIL;
                            end else if (in_byte == CH_COLON) begin
                                key_end = 1'b1;
                            end else begin
                                key_step = 1'b1;
                            end
                        end
                        LP_KEY_TRAIL: begin
                            if (in_byte == CH_COLON) begin
                                key_end = 1'b1;
                            end else if (!ws) begin
                                phase_next = LP_SKIP;
                            end
                        end
                        LP_VALUE: val_step = 1'b1;
                        default: ;
                    endcase
                end

                if (key_step) begin
                    if (kpos_reg >= SME_KEY_LEN || lc != sme_key_char(kpos_reg)) begin
                        kmis_next = 1'b1;
                    end
                    if (kpos_reg != '0 || lc != CH_ALT_L) begin
                        amis_next = 1'b1;
                    end
                    if (kpos_reg < SME_KEY_POS_MAX) begin
                        kpos_next = kpos_reg + 4'd1;
                    end
                end

                if (key_end) begin
                    if (key_hit && !taken_reg) begin
                        taken_next = 1'b1;
                        phase_next = LP_VALUE;
                    end else begin
                        phase_next = LP_SKIP;
                    end
                end

                if (val_step) begin
                    case (vstate_reg)
                        VS_EMPTY: begin
                            if (!ws) begin
                                if (in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                                    neg_next    = (in_byte == CH_MINUS);
                                    vstate_next = VS_SIGN;
                                end else if (dig) begin
                                    vstate_next = VS_DIGITS;
                                    len_next    = LEN_W'(in_byte[3:0]);
                                end else begin
                                    vstate_next = VS_BAD;
                                end
                            end
                        end
                        VS_SIGN, VS_DIGITS: begin
                            if (dig) begin
                                if (len_reg > MAX_L || len_x10 > MAX_P1_W) begin
                                    len_next = MAX_P1;
                                end else begin
                                    len_next = len_x10[LEN_W-1:0];
                                end
                                vstate_next = VS_DIGITS;
                            end else if (ws && vstate_reg == VS_DIGITS) begin
                                vstate_next = VS_TRAIL;
                            end else begin
                                vstate_next = VS_BAD;
                            end
                        end
                        VS_TRAIL: begin
                            if (!ws) begin
                                vstate_next = VS_BAD;
                            end
                        end
                        default: ;
                    endcase
                end

                if (in_byte == CH_LF) begin
                    if (sep_reg inside {SP_CRLF, SP_CRLFCR, SP_LF}) begin
                        sep_done = 1'b1;
                    end else begin
                        sep_next = (sep_reg == SP_CR) ? SP_CRLF : SP_LF;
                    end
                end else if (in_byte == CH_CR) begin
                    sep_next = (sep_reg == SP_CRLF) ? SP_CRLFCR : SP_CR;
                end else begin
                    sep_next = SP_NONE;
                end

                if (sep_done) begin
                    section_next = 1'b1;
                end
            end else begin
                if (!(length_ok(taken_reg, vstate_reg, neg_reg, len_reg) &&
                      LEN_W'(count_reg) >= len_reg)) begin
                    emit = 1'b1;
                    if (count_reg < MAX_C) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
        end

        found      = section_next;
        used       = found && length_ok(taken_next, vstate_next, neg_next, len_next) &&
                     LEN_W'(count_next) == len_next;
        count_wide = 32'(count_next);

        body_res              = '0;
        body_res.result_kind  = RK_BODY;
        body_res.body_byte    = in_byte;

        status_res              = '0;
        status_res.result_kind  = RK_STATUS;
        status_res.header_found = found;
        status_res.length_used  = used;
        status_res.body_length  = count_wide[15:0];
        status_res.is_last      = 1'b1;

        results = '0;
        if (emit) begin
            results.first = body_res;
            results.count = 2'd1;
        end
        if (step && in_last) begin
            if (emit) begin
                results.second = status_res;
                results.count  = 2'd2;
            end else begin
                results.first = status_res;
                results.count = 2'd1;
            end
            section_next = 1'b0;
            sep_next     = SP_NONE;
            phase_next   = LP_LEAD;
            kpos_next    = '0;
            kmis_next    = 1'b0;
            amis_next    = 1'b0;
            taken_next   = 1'b0;
            vstate_next  = VS_EMPTY;
            neg_next     = 1'b0;
            len_next     = '0;
            count_next   = '0;
        end
    end

    a_two_results_order: assert property (@(posedge aclk) disable iff (!aresetn)
        results.count == 2'd2 |->
            results.first.result_kind == RK_BODY && results.second.result_kind == RK_STATUS)
        else $error("second result of a byte is not a status result");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last |=> !section_reg && count_reg == '0 && !taken_reg)
        else $error("message state not cleared after closing byte");

    a_no_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |-> results.count == 2'd0)
        else $error("result produced without an input byte");

    a_length_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_P1)
        else $error("parsed length exceeds its saturation mark");

endmodule

>>> sv/sme_result_fifo.sv
// Result queue: takes up to two results per cycle and hands out one per transfer.
// Depends on sme_pkg.
module sme_result_fifo
    import sme_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  core_out_t            push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_data,
    output logic [SME_PTR_W:0]   level
);

    result_t                mem [SME_FIFO_DEPTH];
    logic [SME_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [SME_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [SME_PTR_W:0]     count_reg, count_next;
    logic                   pop;

    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + SME_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + SME_PTR_W'(pop);
        count_next  = count_reg + (SME_PTR_W + 1)'(push.count) - (SME_PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + SME_PTR_W'(1)] <= push.second;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign level     = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg + (SME_PTR_W + 1)'(push.count) <= (SME_PTR_W + 1)'(SME_FIFO_DEPTH))
        else $error("result queue overflow");

    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd0 && !pop |=> $stable(count_reg))
        else $error("queue level moved without a push or a transfer");

endmodule

>>> sv/sip_message_body_extractor_unit.sv
// Each accepted byte transfer is registered in the input stage and then processed by sme_core;
// its results go into the result queue and are offered on the master side, one result per transfer.
// Throughput: one byte per cycle; a closing byte that also yields a body byte gives two
// results, and s_axis_tready drops while more than four results wait in the queue.
// Reset: aresetn is synchronous, active low, and clears the message state, the input
// stage valid flag and the result queue pointers and level.
module sip_message_body_extractor_unit
    import sme_pkg::*;
#(
    parameter int MAX_BODY_BYTES = SME_MAX_BODY_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] body_byte, [8] header_found,
                                        // [9] length_used, [25:10] body_length, [31:26] zero
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // is_last
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               accept;
    core_out_t          core_results;
    result_t            head;
    logic [SME_PTR_W:0] level;

    assign s_axis_tready = level <= (SME_PTR_W + 1)'(SME_FIFO_DEPTH - 4);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    sme_core #(
        .MAX_BODY_BYTES(MAX_BODY_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_valid_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .results (core_results)
    );

    sme_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_results),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head),
        .level     (level)
    );

    assign m_axis_tdata = {6'b0, head.body_length, head.length_used, head.header_found,
                           head.body_byte};
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.is_last;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sip_message_body_extractor_unit: SIP messages go in as a byte
// stream, and every body byte and status transfer is checked against a built-in predictor.
// Depends on sme_pkg and the unit's RTL only.
module tb;
    import sme_pkg::*;

    localparam int BODY_MAX     = SME_MAX_BODY_BYTES;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 1950;
    localparam int DIR_ROWS     = 6;
    localparam string KEY_TEXT  = "content-length";

    typedef struct packed {
        logic [95:0] text;
        logic [3:0]  n;
        logic        typed;
        logic        found;
        logic        used;
        logic [15:0] len;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{96'h00,        4'd1, 1'b1, 1'b0, 1'b0, 16'd0},
        '{96'hFF,        4'd1, 1'b1, 1'b0, 1'b0, 16'd0},
        '{"\n\n",        4'd2, 1'b1, 1'b1, 1'b0, 16'd0},
        '{"l:1\n\nAB",   4'd7, 1'b0, 1'b0, 1'b0, 16'd0},
        '{"L :-0\n\nZ",  4'd8, 1'b1, 1'b1, 1'b1, 16'd0},
        '{"l:x\n\nQ",    4'd6, 1'b1, 1'b1, 1'b0, 16'd1}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    always #10 aclk = ~aclk;

    sip_message_body_extractor_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic         in_body;
    sep_state_t   sep_st;
    line_phase_t  line_st;
    logic [3:0]   key_pos;
    logic         key_bad;
    logic         alt_bad;
    logic         len_taken;
    value_state_t val_st;
    logic         val_neg;
    logic [16:0]  len_val;
    logic [15:0]  body_cnt;

    result_t    expected_q [$];
    logic [7:0] msg_bytes [$];

    int   wrong_cnt = 0;
    int   msgs_sent = 0;
    int   bytes_sent = 0;
    int   body_seen = 0;
    int   status_seen = 0;
    int   found_seen = 0;
    int   used_seen = 0;
    int   longest_body = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic no_gaps = 1'b0;

    function automatic logic is_blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic length_valid();
        return len_taken && (val_st == VS_DIGITS || val_st == VS_TRAIL)
            && !(val_neg && len_val != 0) && len_val <= BODY_MAX;
    endfunction

    task automatic clear_message_state();
        in_body   = 1'b0;
        sep_st    = SP_NONE;
        line_st   = LP_LEAD;
        key_pos   = '0;
        key_bad   = 1'b0;
        alt_bad   = 1'b0;
        len_taken = 1'b0;
        val_st    = VS_EMPTY;
        val_neg   = 1'b0;
        len_val   = '0;
        body_cnt  = '0;
    endtask

    task automatic take_key_char(input logic [7:0] b);
        logic [7:0] c;
        c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
        if (key_pos >= SME_KEY_LEN || c != KEY_TEXT[key_pos]) key_bad = 1'b1;
        if (key_pos != 0 || c != CH_ALT_L) alt_bad = 1'b1;
        if (key_pos < SME_KEY_POS_MAX) key_pos++;
    endtask

    task automatic close_key();
        if (((key_pos == SME_KEY_LEN && !key_bad) || (key_pos == SME_KEY_ALT_LEN && !alt_bad))
                && !len_taken) begin
            len_taken = 1'b1;
            line_st   = LP_VALUE;
        end else begin
            line_st = LP_SKIP;
        end
    endtask

    task automatic extract_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    dig;
        int      v;
        r = '0;
        if (!in_body) begin
            if (b == CH_LF) begin
                line_st = LP_LEAD;
                key_pos = '0;
                key_bad = 1'b0;
                alt_bad = 1'b0;
            end else begin
                case (line_st)
                    LP_LEAD: begin
                        if (b == CH_COLON) line_st = LP_SKIP;
                        else if (!is_blank(b)) begin
                            take_key_char(b);
                            line_st = LP_KEY;
                        end
                    end
                    LP_KEY: begin
                        if (is_blank(b)) line_st = LP_KEY_TRAIL;
                        else if (b == CH_COLON) close_key();
                        else take_key_char(b);
                    end
                    LP_KEY_TRAIL: begin
                        if (b == CH_COLON) close_key();
                        else if (!is_blank(b)) line_st = LP_SKIP;
                    end
                    LP_VALUE: begin
                        dig = b >= 8'h30 && b <= 8'h39;
                        case (val_st)
                            VS_EMPTY: begin
                                if (b == CH_PLUS || b == CH_MINUS) begin
                                    val_neg = (b == CH_MINUS);
                                    val_st  = VS_SIGN;
                                end else if (dig) begin
                                    len_val = b - 8'h30;
                                    val_st  = VS_DIGITS;
                                end else if (!is_blank(b)) begin
                                    val_st = VS_BAD;
                                end
                            end
                            VS_SIGN, VS_DIGITS: begin
                                if (dig) begin
                                    v = int'(len_val) * 10 + int'(b) - 48;
                                    if (len_val > BODY_MAX || v > BODY_MAX + 1) v = BODY_MAX + 1;
                                    len_val = v[16:0];
                                    val_st  = VS_DIGITS;
                                end else if (is_blank(b) && val_st == VS_DIGITS) begin
                                    val_st = VS_TRAIL;
                                end else begin
                                    val_st = VS_BAD;
                                end
                            end
                            VS_TRAIL: begin
                                if (!is_blank(b)) val_st = VS_BAD;
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            if (b == CH_LF) begin
                if (sep_st == SP_CRLF || sep_st == SP_CRLFCR || sep_st == SP_LF) in_body = 1'b1;
                else sep_st = (sep_st == SP_CR) ? SP_CRLF : SP_LF;
            end else if (b == CH_CR) begin
                sep_st = (sep_st == SP_CRLF) ? SP_CRLFCR : SP_CR;
            end else begin
                sep_st = SP_NONE;
            end
        end else if (!(length_valid() && body_cnt >= len_val)) begin
            r.result_kind = RK_BODY;
            r.body_byte   = b;
            expected_q.push_back(r);
            if (body_cnt < BODY_MAX) body_cnt++;
        end
        if (last) begin
            r = '0;
            r.result_kind  = RK_STATUS;
            r.header_found = in_body;
            r.length_used  = in_body && length_valid() && body_cnt == len_val;
            r.body_length  = body_cnt;
            r.is_last      = 1'b1;
            expected_q.push_back(r);
            clear_message_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_gaps && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        extract_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msgs_sent++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    task automatic put_key(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1) != 0)
                c = c ^ 8'h20;
            msg_bytes.push_back(c);
        end
    endtask

    task automatic put_blanks();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) != 0) msg_bytes.push_back(8'h20);
            else msg_bytes.push_back(8'h09);
        end
    endtask

    task automatic put_eol(input logic crlf);
        if (crlf) msg_bytes.push_back(CH_CR);
        msg_bytes.push_back(CH_LF);
    endtask

    function automatic string pick_value(input int body_len);
        int r;
        r = $urandom_range(0, 22);
        if (r < 8) return $sformatf("%0d", body_len);
        if (r < 10) return $sformatf("%0d", $urandom_range(0, body_len));
        if (r < 12) return $sformatf("%0d", body_len + $urandom_range(1, 6));
        if (r == 12) return $sformatf("+%0d", body_len);
        if (r == 13) return "-0";
        if (r == 14) return $sformatf("-%0d", $urandom_range(1, 9));
        if (r == 15) return $sformatf("00%0d", body_len);
        if (r == 16) return "65535";
        if (r == 17) return "65536";
        if (r == 18) return "4294967296000";
        if (r == 19) return "";
        if (r == 20) return "+";
        if (r == 21) return "1 2";
        return "3x";
    endfunction

    task automatic put_field_line(input logic is_len, input logic crlf, input int body_len);
        if (is_len) begin
            put_blanks();
            if ($urandom_range(0, 1) != 0) put_key("Content-Length");
            else put_key("l");
            put_blanks();
            msg_bytes.push_back(CH_COLON);
            put_blanks();
            put_text(pick_value(body_len));
            put_blanks();
        end else begin
            case ($urandom_range(0, 6))
                0: put_text("Via: SIP/2.0/UDP h1");
                1: put_text("lx: 4");
                2: begin
                    put_key("Content-Lengt");
                    put_text(": 3");
                end
                3: put_text(": 7");
                4: put_text("Call-ID 5a");
                5: put_key("Content-Lengthx: 1");
                default: repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(33, 126)));
            endcase
        end
        put_eol(crlf);
    endtask

    task automatic build_message();
        int   r;
        int   body_len;
        int   lines;
        int   cl_at;
        logic crlf;
        msg_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        crlf     = 1'($urandom_range(0, 1));
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
        lines    = $urandom_range(0, 3);
        cl_at    = $urandom_range(0, lines + 1);
        for (int i = 0; i <= lines; i++) begin
            if (i == cl_at) begin
                put_field_line(1'b1, crlf, body_len);
                if ($urandom_range(0, 5) == 0) put_field_line(1'b1, crlf, body_len);
            end
            if (i < lines) put_field_line(1'b0, crlf, body_len);
        end
        if (r < 14) begin
            if (msg_bytes.size() == 0) msg_bytes.push_back(8'h78);
            return;
        end
        if (msg_bytes.size() == 0) put_eol(crlf);
        if ($urandom_range(0, 9) == 0) put_eol(!crlf);
        else put_eol(crlf);
        repeat (body_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0))
            msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                wrong_cnt++;
                if (wrong_cnt <= 10)
                    $display("unexpected transfer: kind=%0d data=%08h last=%0d",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tuser !== want.result_kind || m_axis_tdata[7:0] !== want.body_byte
                        || m_axis_tdata[8] !== want.header_found
                        || m_axis_tdata[9] !== want.length_used
                        || m_axis_tdata[25:10] !== want.body_length
                        || m_axis_tlast !== want.is_last) begin
                    wrong_cnt++;
                    if (wrong_cnt <= 10)
                        $display({"result %0d wrong: want kind=%0d byte=%02h found=%0d used=%0d",
                                  " len=%0d last=%0d, got kind=%0d byte=%02h found=%0d used=%0d",
                                  " len=%0d last=%0d"},
                                 body_seen + status_seen, want.result_kind, want.body_byte,
                                 want.header_found, want.length_used, want.body_length,
                                 want.is_last, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                                 m_axis_tdata[9], m_axis_tdata[25:10], m_axis_tlast);
                end
                if (want.result_kind == RK_STATUS) begin
                    status_seen++;
                    found_seen += want.header_found;
                    used_seen  += want.length_used;
                    if (want.body_length > longest_body) longest_body = want.body_length;
                end else begin
                    body_seen++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sip_message_body_extractor_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int msg_no;
        int rand_start;
        clear_message_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            msg_bytes.delete();
            for (int k = DIRECTED[i].n - 1; k >= 0; k--) msg_bytes.push_back(DIRECTED[i].text[8*k +: 8]);
            send_message();
            if (DIRECTED[i].typed)
                expected_q[expected_q.size() - 1] = '{RK_STATUS, 8'h00, DIRECTED[i].found,
                                                      DIRECTED[i].used, DIRECTED[i].len, 1'b1};
        end

        msg_no     = 0;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES) begin
            if (msg_no == 10) hold_requests <= hold_requests + 1;
            if (msg_no == 20) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (expected_q.size() != 0);
            end
            no_gaps <= (msg_no >= 30 && msg_no < 45);
            build_message();
            send_message();
            msg_no++;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
        repeat (20) @(posedge aclk);
        if (expected_q.size() != 0) wrong_cnt++;

        $display("covered %0d messages in %0d bytes: %0d body and %0d status transfers checked",
                 msgs_sent, bytes_sent, body_seen, status_seen);
        $display("%0d with a blank line found, %0d framed by length, longest body %0d, %0d wrong",
                 found_seen, used_seen, longest_body, wrong_cnt);
        if (wrong_cnt == 0) begin
            $display("sip_message_body_extractor_unit: match");
        end else begin
            $display("sip_message_body_extractor_unit: mismatch");
        end
        $finish;
    end

endmodule
